// ===== rtl/lpsoc_pkg.sv =====
// Shared types and constants for the layer pixel src-over compositor.
// No dependencies; used by lpsoc_prep, lpsoc_div, the top level and both dv files.
`default_nettype none
package lpsoc_pkg;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_OPACITY       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_PIXEL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd6;

	localparam int LANES   = 3;   // R, G, B quotients
	localparam int QBITS   = 8;   // quotient bits, one divider stage each
	localparam int NUM_W   = 26;
	localparam int DEN_W   = 17;
	localparam int LATENCY = 15;  // start accept to result strobe edge

	typedef struct packed {
		logic        vld;
		logic        bypass;
		logic [7:0]  alpha;
		logic [31:0] dst;
	} side_t;

	typedef logic [LANES-1:0][NUM_W-1:0] num_vec_t;
	typedef logic [LANES-1:0][DEN_W-1:0] den_vec_t;
	typedef logic [LANES-1:0][QBITS-1:0] quo_vec_t;
endpackage
`default_nettype wire

// ===== rtl/layer_pixel_src_over_compositor.sv =====
// Top level: configuration registers, pipeline, output register, assertions.
// Depends on lpsoc_pkg, lpsoc_select, lpsoc_prep, lpsoc_div.
`default_nettype none
// Blends one layer pixel src-over onto one RGBA8 document pixel. A new pixel
// may be started every cycle; busy is high only while coming out of reset.
// Each pixel yields one result_pixel, marked by result_valid, after region
// select, five arithmetic stages, an eight-stage one-bit-per-stage divider
// and the output register. Results come out in start order and cannot be
// held off, so the sink must take one word per cycle. Configuration is
// accepted every cycle on cfg_valid; change it only while no pixel is in
// flight.
module layer_pixel_src_over_compositor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] doc_x,
	input  wire logic [15:0] doc_y,
	input  wire logic [31:0] dst_pixel,
	input  wire logic [63:0] layer_pixel,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [lpsoc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0] cfg_data,
	output logic             result_valid,
	output logic [31:0]      result_pixel
);
	logic [7:0]  opacity_q;
	logic        color_mode_q;
	logic [63:0] dflt_pixel_q;
	logic [16:0] region_left_q;
	logic [16:0] region_top_q;
	logic [15:0] region_width_q;
	logic [15:0] region_height_q;
	logic        ready_q;

	logic                vld_s1;
	logic [63:0]         raw_s1;
	logic [31:0]         dst_s1;
	lpsoc_pkg::side_t    side_s6;
	lpsoc_pkg::num_vec_t num_s6;
	lpsoc_pkg::den_vec_t den_s6;
	lpsoc_pkg::side_t    side_d;
	lpsoc_pkg::quo_vec_t quo_d;

	assign busy      = !ready_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q         <= 1'b0;
			opacity_q       <= 8'd255;
			color_mode_q    <= 1'b0;
			dflt_pixel_q    <= '0;
			region_left_q   <= '0;
			region_top_q    <= '0;
			region_width_q  <= '0;
			region_height_q <= '0;
		end else begin
			ready_q <= 1'b1;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					lpsoc_pkg::REG_OPACITY:       opacity_q       <= cfg_data[7:0];
					lpsoc_pkg::REG_COLOR_MODE:    color_mode_q    <= cfg_data[0];
					lpsoc_pkg::REG_FILL_PIXEL:    dflt_pixel_q    <= cfg_data;
					lpsoc_pkg::REG_REGION_LEFT:   region_left_q   <= cfg_data[16:0];
					lpsoc_pkg::REG_REGION_TOP:    region_top_q    <= cfg_data[16:0];
					lpsoc_pkg::REG_REGION_WIDTH:  region_width_q  <= cfg_data[15:0];
					lpsoc_pkg::REG_REGION_HEIGHT: region_height_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	lpsoc_select u_select (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (start && !busy),
		.doc_x         (doc_x),
		.doc_y         (doc_y),
		.dst_pixel     (dst_pixel),
		.layer_pixel   (layer_pixel),
		.dflt_pixel    (dflt_pixel_q),
		.region_left   (region_left_q),
		.region_top    (region_top_q),
		.region_width  (region_width_q),
		.region_height (region_height_q),
		.vld_s1        (vld_s1),
		.raw_s1        (raw_s1),
		.dst_s1        (dst_s1)
	);

	lpsoc_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_s1     (vld_s1),
		.raw_s1     (raw_s1),
		.dst_s1     (dst_s1),
		.color_mode (color_mode_q),
		.opacity    (opacity_q),
		.side_s6    (side_s6),
		.num_s6     (num_s6),
		.den_s6     (den_s6)
	);

	lpsoc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (side_s6),
		.num_in   (num_s6),
		.den_in   (den_s6),
		.side_out (side_d),
		.quo_out  (quo_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= side_d.vld;
		end
	end

	// zero source alpha passes the destination word through
	always_ff @(posedge clk) begin
		result_pixel <= side_d.bypass ? side_d.dst :
			{side_d.alpha, quo_d[2], quo_d[1], quo_d[0]};
	end

	a_start_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##15 result_valid)
		else $error("accepted word produced no result");

	a_result_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, lpsoc_pkg::LATENCY))
		else $error("result without matching start");

	a_zero_opacity_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && opacity_q == 8'd0) |->
			result_pixel == $past(dst_pixel, lpsoc_pkg::LATENCY))
		else $error("zero opacity altered destination");
endmodule
`default_nettype wire

// ===== rtl/lpsoc_select.sv =====
// Stage 1: region test and choice between layer pixel and default pixel.
// Uses nothing from lpsoc_pkg; its port widths follow the top level.
`default_nettype none
module lpsoc_select (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_vld,
	input  wire logic [15:0] doc_x,
	input  wire logic [15:0] doc_y,
	input  wire logic [31:0] dst_pixel,
	input  wire logic [63:0] layer_pixel,
	input  wire logic [63:0] dflt_pixel,
	input  wire logic [16:0] region_left,
	input  wire logic [16:0] region_top,
	input  wire logic [15:0] region_width,
	input  wire logic [15:0] region_height,
	output logic             vld_s1,
	output logic [63:0]      raw_s1,
	output logic [31:0]      dst_s1
);
	logic [17:0] lx;
	logic [17:0] ly;
	logic        inside_x;
	logic        inside_y;

	always_comb begin
		lx = {2'b00, doc_x} - {region_left[16], region_left};
		ly = {2'b00, doc_y} - {region_top[16], region_top};
		// negative offsets fail on the sign bit; zero size fails the compare
		inside_x = !lx[17] && (lx[16:0] < {1'b0, region_width});
		inside_y = !ly[17] && (ly[16:0] < {1'b0, region_height});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		raw_s1 <= (inside_x && inside_y) ? layer_pixel : dflt_pixel;
		dst_s1 <= dst_pixel;
	end
endmodule
`default_nettype wire

// ===== rtl/lpsoc_prep.sv =====
// Stages 2-6: channel narrowing, source alpha, weighted sums, output alpha,
// divider operands. Depends on lpsoc_pkg (side_t, num_vec_t, den_vec_t, widths).
`default_nettype none
module lpsoc_prep (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            vld_s1,
	input  wire logic [63:0]     raw_s1,
	input  wire logic [31:0]     dst_s1,
	input  wire logic            color_mode,
	input  wire logic [7:0]      opacity,
	output lpsoc_pkg::side_t     side_s6,
	output lpsoc_pkg::num_vec_t  num_s6,
	output lpsoc_pkg::den_vec_t  den_s6
);
	logic [3:0][32:0] nprod;
	logic [3:0][7:0]  ch_c;

	logic             vld_s2, vld_s3, vld_s4, vld_s5;
	logic [31:0]      dst_s2, dst_s3, dst_s4, dst_s5;
	logic [3:0][7:0]  ch_s2;
	logic [2:0][7:0]  ch_s3, ch_s4;
	logic [15:0]      aprod_s3;
	logic [33:0]      sprod;
	logic [7:0]       sa_s4;
	logic [7:0]       isa;
	logic [2:0][15:0] ss_s5, dd_s5;
	logic [7:0]       isa_s5;
	logic [15:0]      o_s5;
	logic             bypass_s5;
	logic [2:0][23:0] n_c;
	logic [33:0]      alpha_prod;

	// (v + 128) / 257 as a multiply by ceil(2^24/257), exact for 17-bit v
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			nprod[i] = {16'b0, {1'b0, raw_s1[16*i +: 16]} + 17'd128} * 33'd65281;
			ch_c[i]  = color_mode ? nprod[i][31:24] : raw_s1[8*i +: 8];
		end
	end

	// x / 255 as a multiply by ceil(2^25/255), exact for 16-bit x
	assign sprod = {18'b0, aprod_s3} * 34'd131587;
	assign isa   = 8'd255 - sa_s4;

	// output alpha: (2*O + 255) / 510 equals (O + 127) / 255
	assign alpha_prod = {18'b0, o_s5 + 16'd127} * 34'd131587;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i] = ({ss_s5[i], 8'b0} - {8'b0, ss_s5[i]})
			         + ({8'b0, dd_s5[i]} * {16'b0, isa_s5});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			side_s6 <= '0;
		end else begin
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			side_s6 <= '{vld: vld_s5, bypass: bypass_s5, alpha: alpha_prod[32:25],
				dst: dst_s5};
		end
	end

	always_ff @(posedge clk) begin
		ch_s2    <= ch_c;
		dst_s2   <= dst_s1;

		aprod_s3 <= {8'b0, ch_s2[3]} * {8'b0, opacity};
		ch_s3    <= ch_s2[2:0];
		dst_s3   <= dst_s2;

		sa_s4    <= sprod[32:25];
		ch_s4    <= ch_s3;
		dst_s4   <= dst_s3;

		for (int i = 0; i < 3; i++) begin
			ss_s5[i] <= {8'b0, ch_s4[i]} * {8'b0, sa_s4};
			dd_s5[i] <= {8'b0, dst_s4[8*i +: 8]} * {8'b0, dst_s4[31:24]};
		end
		isa_s5    <= isa;
		o_s5      <= ({sa_s4, 8'b0} - {8'b0, sa_s4}) + ({8'b0, dst_s4[31:24]} * {8'b0, isa});
		bypass_s5 <= (sa_s4 == 8'd0);
		dst_s5    <= dst_s4;

		for (int i = 0; i < 3; i++) begin
			num_s6[i] <= {1'b0, n_c[i], 1'b0} + {10'b0, o_s5};
			den_s6[i] <= {o_s5, 1'b0};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/lpsoc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// Depends on lpsoc_pkg (side_t, vector types, QBITS, widths).
`default_nettype none
module lpsoc_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lpsoc_pkg::side_t    side_in,
	input  wire lpsoc_pkg::num_vec_t num_in,
	input  wire lpsoc_pkg::den_vec_t den_in,
	output lpsoc_pkg::side_t         side_out,
	output lpsoc_pkg::quo_vec_t      quo_out
);
	localparam int QB = lpsoc_pkg::QBITS;
	localparam int NW = lpsoc_pkg::NUM_W;
	localparam int DW = lpsoc_pkg::DEN_W;

	lpsoc_pkg::side_t    side_s [QB];
	lpsoc_pkg::num_vec_t rem_s  [QB];
	lpsoc_pkg::den_vec_t den_s  [QB];
	lpsoc_pkg::quo_vec_t quo_s  [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		lpsoc_pkg::side_t    side_p;
		lpsoc_pkg::num_vec_t rem_p;
		lpsoc_pkg::den_vec_t den_p;
		lpsoc_pkg::quo_vec_t quo_p;
		lpsoc_pkg::num_vec_t rem_n;
		lpsoc_pkg::quo_vec_t quo_n;
		logic [lpsoc_pkg::LANES-1:0][NW-1:0] sh;

		if (k == 0) begin : g_first
			assign side_p = side_in;
			assign rem_p  = num_in;
			assign den_p  = den_in;
			assign quo_p  = '0;
		end else begin : g_next
			assign side_p = side_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign den_p  = den_s[k-1];
			assign quo_p  = quo_s[k-1];
		end

		// quotient fits in QB bits, so the shifted divisor never overflows
		always_comb begin
			for (int l = 0; l < lpsoc_pkg::LANES; l++) begin
				sh[l]    = {{(NW-DW){1'b0}}, den_p[l]} << (QB - 1 - k);
				quo_n[l] = {quo_p[l][QB-2:0], rem_p[l] >= sh[l]};
				rem_n[l] = (rem_p[l] >= sh[l]) ? rem_p[l] - sh[l] : rem_p[l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else begin
				side_s[k] <= side_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= rem_n;
			den_s[k] <= den_p;
			quo_s[k] <= quo_n;
		end
	end

	assign side_out = side_s[QB-1];
	assign quo_out  = quo_s[QB-1];
endmodule
`default_nettype wire

// ===== dv/lpsoc_checker.sv =====
// Checker for the layer pixel src-over compositor: tracks register writes,
// predicts each blended word and compares it with result_pixel.
// Depends on lpsoc_pkg for the register index codes.
module lpsoc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [15:0] doc_x,
	input  wire logic [15:0] doc_y,
	input  wire logic [31:0] dst_pixel,
	input  wire logic [63:0] layer_pixel,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [lpsoc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        result_valid,
	input  wire logic [31:0] result_pixel,
	output int               fail_count,
	output int               pending
);
	logic [7:0]         opacity_r;
	logic               mode16_r;
	logic [63:0]        default_px_r;
	logic signed [16:0] left_r;
	logic signed [16:0] top_r;
	logic [15:0]        width_r;
	logic [15:0]        height_r;
	logic [31:0]        blend_q[$];

	function automatic logic [31:0] blend_src_over(logic [15:0] x, logic [15:0] y,
			logic [31:0] dst, logic [63:0] raw);
		int           lx, ly;
		longint       s[4], d[4];
		longint       sa, o, n, c, a;
		logic [31:0]  res;
		logic [15:0]  v;
		lx = int'({1'b0, x}) - int'(left_r);
		ly = int'({1'b0, y}) - int'(top_r);
		if (width_r == 0 || height_r == 0 || lx < 0 || lx >= int'(width_r) ||
				ly < 0 || ly >= int'(height_r))
			raw = default_px_r;
		for (int i = 0; i < 4; i++) begin
			if (mode16_r) begin
				v = raw[16*i +: 16];
				s[i] = (longint'(v) + 128) / 257;
			end else begin
				s[i] = longint'(raw[8*i +: 8]);
			end
			d[i] = longint'(dst[8*i +: 8]);
		end
		sa = s[3] * longint'(opacity_r) / 255;
		if (sa == 0)
			return dst;
		o = 255 * sa + d[3] * (255 - sa);
		for (int i = 0; i < 3; i++) begin
			n = s[i] * sa * 255 + d[i] * d[3] * (255 - sa);
			c = (2 * n + o) / (2 * o);
			if (c > 255)
				c = 255;
			res[8*i +: 8] = c[7:0];
		end
		a = (2 * o + 255) / 510;
		if (a > 255)
			a = 255;
		res[31:24] = a[7:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			opacity_r    <= 8'd255;
			mode16_r     <= 1'b0;
			default_px_r <= '0;
			left_r       <= '0;
			top_r        <= '0;
			width_r      <= '0;
			height_r     <= '0;
			fail_count   <= 0;
			pending      <= 0;
			blend_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lpsoc_pkg::REG_OPACITY:       opacity_r    <= cfg_data[7:0];
					lpsoc_pkg::REG_COLOR_MODE:    mode16_r     <= cfg_data[0];
					lpsoc_pkg::REG_FILL_PIXEL:    default_px_r <= cfg_data;
					lpsoc_pkg::REG_REGION_LEFT:   left_r       <= cfg_data[16:0];
					lpsoc_pkg::REG_REGION_TOP:    top_r        <= cfg_data[16:0];
					lpsoc_pkg::REG_REGION_WIDTH:  width_r      <= cfg_data[15:0];
					lpsoc_pkg::REG_REGION_HEIGHT: height_r     <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (start && !busy)
				blend_q.insert(blend_q.size(),
					blend_src_over(doc_x, doc_y, dst_pixel, layer_pixel));
			if (result_valid) begin
				if (blend_q.size() == 0) begin
					$error("result_pixel with no word expected: actual %h", result_pixel);
					fail_count <= fail_count + 1;
				end else begin
					want = blend_q.pop_front();
					if (want !== result_pixel) begin
						$error("result_pixel mismatch: expected %h actual %h",
							want, result_pixel);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= blend_q.size();
		end
	end
endmodule

// ===== dv/tb_layer_pixel_src_over_compositor.sv =====
// Testbench top for the layer pixel src-over compositor: clock, reset,
// register writes and pixel stimulus; lpsoc_checker does the scoreboarding.
// Depends on lpsoc_pkg, lpsoc_checker and the compositor RTL.
module tb_layer_pixel_src_over_compositor;
	localparam logic [lpsoc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 200;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] doc_x;
	logic [15:0] doc_y;
	logic [31:0] dst_pixel;
	logic [63:0] layer_pixel;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [lpsoc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;
	logic        result_valid;
	logic [31:0] result_pixel;
	int          fail_count;
	int          pending;
	int          cycles;
	int          words_sent;
	int          cur_left, cur_top, cur_w, cur_h;

	layer_pixel_src_over_compositor u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.doc_x(doc_x), .doc_y(doc_y), .dst_pixel(dst_pixel),
		.layer_pixel(layer_pixel), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .result_pixel(result_pixel)
	);

	lpsoc_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.doc_x(doc_x), .doc_y(doc_y), .dst_pixel(dst_pixel),
		.layer_pixel(layer_pixel), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .result_pixel(result_pixel),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(logic [lpsoc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// pending is registered, so the task steps the clock before trusting it
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_word(logic [15:0] x, logic [15:0] y, logic [31:0] d,
			logic [63:0] l, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		doc_x       <= x;
		doc_y       <= y;
		dst_pixel   <= d;
		layer_pixel <= l;
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	task automatic configure(logic [7:0] opa, logic mode, logic [63:0] dflt,
			int left, int top_row, int w, int h);
		start <= 1'b0;
		wait_drained();
		// junk in the upper bits checks that the block masks them
		write_reg(lpsoc_pkg::REG_OPACITY, {$urandom, 24'($urandom), opa});
		write_reg(lpsoc_pkg::REG_COLOR_MODE, {$urandom, 31'($urandom), mode});
		write_reg(lpsoc_pkg::REG_FILL_PIXEL, dflt);
		write_reg(lpsoc_pkg::REG_REGION_LEFT, {$urandom, 15'($urandom), 17'(left)});
		write_reg(lpsoc_pkg::REG_REGION_TOP, {$urandom, 15'($urandom), 17'(top_row)});
		write_reg(lpsoc_pkg::REG_REGION_WIDTH, {$urandom, 16'($urandom), 16'(w)});
		write_reg(lpsoc_pkg::REG_REGION_HEIGHT, {$urandom, 16'($urandom), 16'(h)});
		cur_left = left;
		cur_top  = top_row;
		cur_w    = w;
		cur_h    = h;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [15:0] near_coord(int base, int span);
		return 16'(base + $urandom_range(0, span + 1) - 1);
	endfunction

	initial begin
		logic [7:0] opa;
		int         left, top_row, w, h, gap_max, pick;
		logic [15:0] x, y;
		cycles      = 0;
		words_sent  = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		doc_x       = '0;
		doc_y       = '0;
		dst_pixel   = '0;
		layer_pixel = '0;
		cfg_valid   = 1'b0;
		cfg_index   = lpsoc_pkg::REG_OPACITY;
		cfg_data    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: empty region, default pixel transparent
		send_word(16'd0, 16'd0, 32'h80_40_20_10, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_word(16'hFFFF, 16'hFFFF, 32'hFF_FF_FF_FF, 64'hFFFF_FFFF_FFFF_FFFF, 0);

		start <= 1'b0;
		wait_drained();
		write_reg(REG_UNMAPPED, rand64());
		configure(8'd255, 1'b0, 64'h0000_0000_80_33_66_99, 10, 20, 5, 5);
		send_word(16'd10, 16'd20, 32'h00_00_00_00, 64'hDEAD_BEEF_FF_30_20_10, 0);
		send_word(16'd14, 16'd24, 32'hFF_FF_FF_FF, 64'h0000_0000_80_00_FF_7F, 0);
		send_word(16'd15, 16'd20, 32'hFF_10_20_30, 64'h0000_0000_FF_FF_FF_FF, 1);
		send_word(16'd9, 16'd20, 32'h00_10_20_30, 64'h0000_0000_FF_FF_FF_FF, 0);
		send_word(16'd10, 16'd25, 32'h7F_AA_55_AA, 64'h0000_0000_FF_FF_FF_FF, 0);
		send_word(16'd12, 16'd19, 32'h7F_AA_55_AA, 64'h0000_0000_FF_FF_FF_FF, 0);
		send_word(16'd11, 16'd21, 32'h12_34_56_78, 64'h0000_0000_00_FF_FF_FF, 2);
		send_word(16'd13, 16'd22, 32'h01_FF_00_FF, 64'h0000_0000_01_00_FF_00, 0);

		configure(8'd0, 1'b0, 64'h0000_0000_FF_FF_FF_FF, 0, 0, 65535, 65535);
		send_word(16'd100, 16'd100, 32'h11_22_33_44, 64'h0000_0000_FF_FF_FF_FF, 0);
		send_word(16'hFFFF, 16'hFFFF, 32'h55_66_77_88, 64'hFFFF_FFFF_FFFF_FFFF, 0);

		// 16-bit channels around the narrowing boundary, region off the top-left edge
		configure(8'd128, 1'b1, 64'h0080_007F_FFFF_0000, -65536, -65536, 65535, 65535);
		send_word(16'd0, 16'd0, 32'hFF_00_80_FF, 64'hFFFF_0080_007F_FFFF, 0);
		send_word(16'hFFFE, 16'hFFFE, 32'h00_FF_FF_FF, 64'hFF7F_FF80_0000_FFFF, 0);
		send_word(16'hFFFF, 16'd5, 32'h80_01_02_03, 64'h0000_0000_0000_0000, 0);
		send_word(16'd7, 16'hFFFF, 32'h80_01_02_03, 64'h8080_1234_ABCD_0100, 0);

		configure(8'd255, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 65535, 65535, 1, 1);
		send_word(16'hFFFF, 16'hFFFF, 32'h00_00_00_00, 64'h0000_8000_4000_2000, 0);
		send_word(16'hFFFE, 16'hFFFF, 32'h40_80_C0_FF, 64'h0000_8000_4000_2000, 0);

		for (int p = 0; p < PHASES; p++) begin
			pick = $urandom_range(0, 3);
			opa = (pick == 0) ? 8'd255 : (pick == 1) ? 8'd0 : 8'($urandom);
			pick = $urandom_range(0, 5);
			left    = (pick == 0) ? -65536 : (pick == 1) ? 65535 :
				$urandom_range(0, 2000) - 500;
			top_row = (pick == 0) ? -65536 : (pick == 1) ? 65535 :
				$urandom_range(0, 2000) - 500;
			pick = $urandom_range(0, 5);
			w = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(1, 64);
			h = (pick == 2) ? 0 : (pick == 3) ? 65535 : $urandom_range(1, 64);
			configure(opa, 1'($urandom), rand64(), left, top_row, w, h);
			gap_max = (p % 3 == 1) ? 0 : 10;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == PHASE_ITEMS / 2) begin
					start <= 1'b0;
					wait_drained();
				end
				if ($urandom_range(0, 3) == 0) begin
					x = 16'($urandom);
					y = 16'($urandom);
				end else begin
					x = near_coord(cur_left, cur_w);
					y = near_coord(cur_top, cur_h);
				end
				send_word(x, y, $urandom, rand64(), $urandom_range(0, gap_max));
			end
		end

		start <= 1'b0;
		wait_drained();
		repeat (lpsoc_pkg::LATENCY + 5) @(posedge clk);
		$display("Sent %0d pixels over %0d random register settings plus directed cases",
			words_sent, PHASES);
		$display("covering both pixel formats, region edges, empty regions and zero opacity");
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			if (pending != 0)
				$error("%0d expected words never arrived", pending);
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/lpsoc_pkg.sv
rtl/lpsoc_select.sv
rtl/lpsoc_prep.sv
rtl/lpsoc_div.sv
rtl/layer_pixel_src_over_compositor.sv
dv/lpsoc_checker.sv
dv/tb_layer_pixel_src_over_compositor.sv
